// File: hdl/point_in_polygon_test_macros.svh
// Assertion macros shared by the point-in-polygon test RTL.
// Depends on nothing; included by the modules that carry assertions.
// SYNTH set at compile time turns every assertion into nothing.
`ifndef POINT_IN_POLYGON_TEST_MACROS_SVH
`define POINT_IN_POLYGON_TEST_MACROS_SVH
`ifndef SYNTH
// Checks a property on every rising clock edge outside reset.
`define PIPT_ASSERT(label, clk, rstn, prop) \
  label: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pipt assertion failed");
// Checks that a condition in one cycle brings a consequence in the next.
`define PIPT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pipt assertion failed");
`else
`define PIPT_ASSERT(label, clk, rstn, prop)
`define PIPT_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

// File: hdl/pipt_pkg.sv
// Shared types and constants of the point-in-polygon test block.
// Depends on nothing; used by every module of the block.
package pipt_pkg;

  localparam int unsigned MAX_VERTICES_DEF = 256;
  localparam int unsigned COORD_BITS_DEF   = 32;

  localparam int unsigned FIELD_W     = 32;
  localparam int unsigned OPCODE_W    = 2;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned COUNT_OUT_W = 9;
  localparam int unsigned MIN_VERTICES = 3;
  localparam int unsigned QUEUE_DEPTH = 2;

  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 16;

  localparam logic [OPCODE_W-1:0] OP_APPEND = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_CLEAR  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_QUERY  = 2'd2;

  localparam logic [STATUS_W-1:0] STAT_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_DEGENERATE = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_FULL       = 2'd2;

  typedef enum logic [1:0] {
    CMD_APPEND,
    CMD_CLEAR,
    CMD_QUERY,
    CMD_NOP
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [FIELD_W-1:0] x;
    logic [FIELD_W-1:0] y;
  } cmd_t;

endpackage

// File: hdl/pipt_front.sv
// Front end: takes input requests, decodes the opcode into a command kind
// and holds commands in a short queue for the back end. Uses pipt_pkg.
`include "point_in_polygon_test_macros.svh"

module pipt_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  logic [pipt_pkg::OPCODE_W-1:0] opcode_i,
  input  logic [pipt_pkg::FIELD_W-1:0]  x_i,
  input  logic [pipt_pkg::FIELD_W-1:0]  y_i,
  output logic                          cmd_valid_o,
  output pipt_pkg::cmd_t                cmd_o,
  input  logic                          cmd_pop_i
);

  localparam int unsigned PTR_W = (pipt_pkg::QUEUE_DEPTH > 1) ?
                                  $clog2(pipt_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned FILL_W = $clog2(pipt_pkg::QUEUE_DEPTH + 1);

  pipt_pkg::cmd_t      entry_q [pipt_pkg::QUEUE_DEPTH];
  pipt_pkg::cmd_t      new_cmd;
  pipt_pkg::cmd_kind_e kind;
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0]   fill_q, fill_d;
  logic                push;

  always_comb begin
    case (opcode_i)
      pipt_pkg::OP_APPEND: kind = pipt_pkg::CMD_APPEND;
      pipt_pkg::OP_CLEAR:  kind = pipt_pkg::CMD_CLEAR;
      pipt_pkg::OP_QUERY:  kind = pipt_pkg::CMD_QUERY;
      default:             kind = pipt_pkg::CMD_NOP;
    endcase
  end

  always_comb begin
    new_cmd.kind = kind;
    new_cmd.x    = x_i;
    new_cmd.y    = y_i;
  end

  assign s_ready_o   = (fill_q != FILL_W'(pipt_pkg::QUEUE_DEPTH));
  assign push        = s_valid_i && s_ready_o;
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(pipt_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 wr_ptr_q + PTR_W'(1);
    end
    if (cmd_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(pipt_pkg::QUEUE_DEPTH - 1)) ? '0 :
                 rd_ptr_q + PTR_W'(1);
    end
    case ({push, cmd_pop_i})
      2'b10:   fill_d = fill_q + FILL_W'(1);
      2'b01:   fill_d = fill_q - FILL_W'(1);
      default: fill_d = fill_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= new_cmd;
    end
  end

  `PIPT_ASSERT(a_pop_not_empty, clk_i, rst_ni, cmd_pop_i |-> (fill_q != '0))
  `PIPT_ASSERT_NEXT(a_push_only_fills, clk_i, rst_ni, push && !cmd_pop_i, fill_q != '0)

endmodule

// File: hdl/pipt_cross.sv
// Edge crossing unit: two pipeline stages that decide whether one polygon
// edge flips the inside flag for the test point. Uses pipt_pkg.
`include "point_in_polygon_test_macros.svh"

module pipt_cross #(
  parameter int unsigned COORD_BITS = pipt_pkg::COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         edge_valid_i,
  input  logic signed [COORD_BITS-1:0] px_i,
  input  logic signed [COORD_BITS-1:0] py_i,
  input  logic signed [COORD_BITS-1:0] xi_i,
  input  logic signed [COORD_BITS-1:0] yi_i,
  input  logic signed [COORD_BITS-1:0] xj_i,
  input  logic signed [COORD_BITS-1:0] yj_i,
  output logic                         toggle_o,
  output logic                         busy_o
);

  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned MW = COORD_BITS;
  localparam int unsigned PW = 2 * COORD_BITS;

  logic signed [DW-1:0] d_a, d_dy, d_b, d_c;
  logic signed [DW-1:0] n_a, n_dy, n_b, n_c;
  logic [MW-1:0]        m_a, m_dy, m_b, m_c;
  logic                 straddle, dy_pos, neg_l, neg_r;

  logic          a_v_q, a_nl_q, a_nr_q, a_str_q, a_dyp_q;
  logic [MW-1:0] a_ma_q, a_mdy_q, a_mb_q, a_mc_q;
  logic          b_v_q, b_nl_q, b_nr_q, b_str_q, b_dyp_q;
  logic [PW-1:0] b_ml_q, b_mr_q;
  logic          l_lt_r, r_lt_l, hit;

  // Differences need one bit more than a coordinate; their magnitudes do not.
  always_comb begin
    d_a  = {px_i[MW-1], px_i} - {xi_i[MW-1], xi_i};
    d_dy = {yj_i[MW-1], yj_i} - {yi_i[MW-1], yi_i};
    d_b  = {xj_i[MW-1], xj_i} - {xi_i[MW-1], xi_i};
    d_c  = {py_i[MW-1], py_i} - {yi_i[MW-1], yi_i};
    n_a  = -d_a;
    n_dy = -d_dy;
    n_b  = -d_b;
    n_c  = -d_c;
    m_a  = d_a[DW-1]  ? n_a[MW-1:0]  : d_a[MW-1:0];
    m_dy = d_dy[DW-1] ? n_dy[MW-1:0] : d_dy[MW-1:0];
    m_b  = d_b[DW-1]  ? n_b[MW-1:0]  : d_b[MW-1:0];
    m_c  = d_c[DW-1]  ? n_c[MW-1:0]  : d_c[MW-1:0];
    straddle = (yi_i > py_i) != (yj_i > py_i);
    dy_pos   = (yj_i > yi_i);
    // A zero product is never negative.
    neg_l = (d_a[DW-1] ^ d_dy[DW-1]) && (m_a != '0) && (m_dy != '0);
    neg_r = (d_b[DW-1] ^ d_c[DW-1]) && (m_b != '0) && (m_c != '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
    end else begin
      a_v_q <= edge_valid_i;
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    a_ma_q  <= m_a;
    a_mdy_q <= m_dy;
    a_mb_q  <= m_b;
    a_mc_q  <= m_c;
    a_nl_q  <= neg_l;
    a_nr_q  <= neg_r;
    a_str_q <= straddle;
    a_dyp_q <= dy_pos;
    b_ml_q  <= a_ma_q * a_mdy_q;
    b_mr_q  <= a_mb_q * a_mc_q;
    b_nl_q  <= a_nl_q;
    b_nr_q  <= a_nr_q;
    b_str_q <= a_str_q;
    b_dyp_q <= a_dyp_q;
  end

  // The crossing lies right of the point when (px - xi) * dy is below
  // (xj - xi) * (py - yi), the order reversing for a falling edge.
  always_comb begin
    if (b_nl_q != b_nr_q) begin
      l_lt_r = b_nl_q;
      r_lt_l = b_nr_q;
    end else if (b_nl_q) begin
      l_lt_r = (b_ml_q > b_mr_q);
      r_lt_l = (b_mr_q > b_ml_q);
    end else begin
      l_lt_r = (b_ml_q < b_mr_q);
      r_lt_l = (b_mr_q < b_ml_q);
    end
    hit = b_dyp_q ? l_lt_r : r_lt_l;
  end

  assign toggle_o = b_v_q && b_str_q && hit;
  assign busy_o   = a_v_q || b_v_q;

  `PIPT_ASSERT_NEXT(a_edge_reaches_b, clk_i, rst_ni, edge_valid_i, busy_o)
  `PIPT_ASSERT(a_toggle_needs_straddle, clk_i, rst_ni, toggle_o |-> (b_v_q && b_str_q))

endmodule

// File: hdl/pipt_back.sv
// Back end: vertex memory, vertex count, edge walk sequencer and result
// register. Instantiates pipt_cross; uses pipt_pkg.
`include "point_in_polygon_test_macros.svh"

module pipt_back #(
  parameter int unsigned MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = pipt_pkg::COORD_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cmd_valid_i,
  input  pipt_pkg::cmd_t                   cmd_i,
  output logic                             cmd_pop_o,
  output logic                             res_valid_o,
  input  logic                             res_ready_i,
  output logic                             res_inside_o,
  output logic [pipt_pkg::STATUS_W-1:0]    res_status_o,
  output logic [pipt_pkg::COUNT_OUT_W-1:0] res_count_o
);

  localparam int unsigned ADDR_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_VERTICES + 1);
  localparam int unsigned EXT_W  = CNT_W + pipt_pkg::COUNT_OUT_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN
  } state_e;

  state_e state_q;

  logic signed [COORD_BITS-1:0] mem_x [MAX_VERTICES];
  logic signed [COORD_BITS-1:0] mem_y [MAX_VERTICES];

  logic [CNT_W-1:0]   count_q, count_d;
  logic [CNT_W-1:0]   walk_q;
  logic [CNT_W-1:0]   addr_base, addr_full;
  logic [ADDR_W-1:0]  rd_addr, wr_addr;
  logic [EXT_W-1:0]   count_ext;
  logic               rd_v_q, rd_first_q, inside_q;
  logic               out_valid_q, out_inside_q;
  logic [pipt_pkg::STATUS_W-1:0]    out_status_q, imm_status;
  logic [pipt_pkg::COUNT_OUT_W-1:0] out_count_q;
  logic               full, degenerate, out_free, wr_en, start_walk;
  logic               cross_toggle, cross_busy;

  logic signed [COORD_BITS-1:0] cmd_x, cmd_y;
  logic signed [COORD_BITS-1:0] px_q, py_q, rd_x_q, rd_y_q, prev_x_q, prev_y_q;

  assign cmd_x      = cmd_i.x[COORD_BITS-1:0];
  assign cmd_y      = cmd_i.y[COORD_BITS-1:0];
  assign full       = (count_q == CNT_W'(MAX_VERTICES));
  assign degenerate = (count_q < CNT_W'(pipt_pkg::MIN_VERTICES));
  assign out_free   = !out_valid_q || res_ready_i;
  assign cmd_pop_o  = (state_q == S_IDLE) && cmd_valid_i && out_free;
  assign wr_addr    = count_q[ADDR_W-1:0];
  assign wr_en      = cmd_pop_o && (cmd_i.kind == pipt_pkg::CMD_APPEND) && !full;

  // The walk reads the last vertex first, then vertex 0 upward, so each edge
  // pairs the vertex just read with the one read before it.
  assign addr_base = (walk_q == '0) ? count_q : walk_q;
  assign addr_full = addr_base - CNT_W'(1);
  assign rd_addr   = addr_full[ADDR_W-1:0];

  always_comb begin
    count_d    = count_q;
    imm_status = pipt_pkg::STAT_OK;
    start_walk = 1'b0;
    if (cmd_pop_o) begin
      case (cmd_i.kind)
        pipt_pkg::CMD_APPEND: begin
          if (full) begin
            imm_status = pipt_pkg::STAT_FULL;
          end else begin
            count_d = count_q + CNT_W'(1);
          end
        end
        pipt_pkg::CMD_CLEAR: begin
          count_d = '0;
        end
        pipt_pkg::CMD_QUERY: begin
          if (degenerate) begin
            imm_status = pipt_pkg::STAT_DEGENERATE;
          end else begin
            start_walk = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign count_ext = EXT_W'(count_d);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_x[wr_addr] <= cmd_x;
      mem_y[wr_addr] <= cmd_y;
    end
    rd_x_q <= mem_x[rd_addr];
    rd_y_q <= mem_y[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (start_walk) begin
      px_q <= cmd_x;
      py_q <= cmd_y;
    end
    if (rd_v_q) begin
      prev_x_q <= rd_x_q;
      prev_y_q <= rd_y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      walk_q       <= '0;
      rd_v_q       <= 1'b0;
      rd_first_q   <= 1'b0;
      inside_q     <= 1'b0;
      out_valid_q  <= 1'b0;
      out_inside_q <= 1'b0;
      out_status_q <= pipt_pkg::STAT_OK;
      out_count_q  <= '0;
    end else begin
      count_q <= count_d;
      rd_v_q  <= 1'b0;
      if (out_valid_q && res_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cross_toggle) begin
        inside_q <= !inside_q;
      end
      case (state_q)
        S_IDLE: begin
          if (start_walk) begin
            state_q  <= S_WALK;
            walk_q   <= '0;
            inside_q <= 1'b0;
          end else if (cmd_pop_o) begin
            out_valid_q  <= 1'b1;
            out_inside_q <= 1'b0;
            out_status_q <= imm_status;
            out_count_q  <= count_ext[pipt_pkg::COUNT_OUT_W-1:0];
          end
        end
        S_WALK: begin
          rd_v_q     <= 1'b1;
          rd_first_q <= (walk_q == '0);
          if (walk_q == count_q) begin
            state_q <= S_DRAIN;
          end else begin
            walk_q <= walk_q + CNT_W'(1);
          end
        end
        S_DRAIN: begin
          if (!rd_v_q && !cross_busy) begin
            state_q      <= S_IDLE;
            out_valid_q  <= 1'b1;
            out_inside_q <= inside_q;
            out_status_q <= pipt_pkg::STAT_OK;
            out_count_q  <= count_ext[pipt_pkg::COUNT_OUT_W-1:0];
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  pipt_cross #(
    .COORD_BITS(COORD_BITS)
  ) u_cross (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .edge_valid_i(rd_v_q && !rd_first_q),
    .px_i        (px_q),
    .py_i        (py_q),
    .xi_i        (rd_x_q),
    .yi_i        (rd_y_q),
    .xj_i        (prev_x_q),
    .yj_i        (prev_y_q),
    .toggle_o    (cross_toggle),
    .busy_o      (cross_busy)
  );

  assign res_valid_o  = out_valid_q;
  assign res_inside_o = out_inside_q;
  assign res_status_o = out_status_q;
  assign res_count_o  = out_count_q;

  `PIPT_ASSERT_NEXT(a_count_held_in_walk, clk_i, rst_ni, state_q != S_IDLE, $stable(count_q))
  `PIPT_ASSERT(a_toggle_in_query, clk_i, rst_ni, cross_toggle |-> (state_q == S_WALK || state_q == S_DRAIN))
  `PIPT_ASSERT(a_out_empty_in_walk, clk_i, rst_ni, (state_q == S_WALK) |-> !out_valid_q)

endmodule

// File: hdl/point_in_polygon_test.sv
// Top level of the point-in-polygon test block: stream ports, front end
// with command queue and back end with vertex memory. Uses pipt_pkg.
//
// The block holds one polygon of up to MAX_VERTICES vertices, appended one
// per request, and answers each request with exactly one result. With the
// back end idle, append, clear and unused opcodes are answered from the
// result register once popped from the queue, and a query on a polygon of
// n vertices (n of at least three) runs an edge walk that reads one vertex
// per cycle from the single read port of the vertex memory and feeds one
// edge per cycle into the two-stage crossing unit. A two-entry command
// queue keeps taking requests while a query runs or a result waits to be
// taken.
// Coordinates are signed Q16.16; only the low COORD_BITS bits are used.
// The vertex memory needs no clearing after reset.
module point_in_polygon_test #(
  parameter int unsigned MAX_VERTICES = pipt_pkg::MAX_VERTICES_DEF,
  parameter int unsigned COORD_BITS   = pipt_pkg::COORD_BITS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // coord_x [31:0], coord_y [63:32]
  input  logic [pipt_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // opcode [1:0]
  input  logic [pipt_pkg::OPCODE_W-1:0]       s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // inside_res [0], status [2:1], vertex_count [11:3], zero [15:12]
  output logic [pipt_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

  logic                             cmd_valid, cmd_pop;
  pipt_pkg::cmd_t                   cmd;
  logic                             res_inside;
  logic [pipt_pkg::STATUS_W-1:0]    res_status;
  logic [pipt_pkg::COUNT_OUT_W-1:0] res_count;

  pipt_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid),
    .s_ready_o  (s_axis_tready),
    .opcode_i   (s_axis_tuser),
    .x_i        (s_axis_tdata[pipt_pkg::FIELD_W-1:0]),
    .y_i        (s_axis_tdata[2*pipt_pkg::FIELD_W-1:pipt_pkg::FIELD_W]),
    .cmd_valid_o(cmd_valid),
    .cmd_o      (cmd),
    .cmd_pop_i  (cmd_pop)
  );

  pipt_back #(
    .MAX_VERTICES(MAX_VERTICES),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_inside_o(res_inside),
    .res_status_o(res_status),
    .res_count_o (res_count)
  );

  assign m_axis_tdata = {
    {(pipt_pkg::OUT_TDATA_W - pipt_pkg::COUNT_OUT_W - pipt_pkg::STATUS_W - 1){1'b0}},
    res_count, res_status, res_inside
  };

endmodule

// File: verif/tb.sv
// Self-checking testbench of the point-in-polygon test block: directed rows,
// then random polygon sessions, checked against a predictor kept in the bench.
// Depends on pipt_pkg and on the point_in_polygon_test top level.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAX_V = pipt_pkg::MAX_VERTICES_DEF;
  localparam logic [pipt_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
  localparam logic [31:0] CMIN  = 32'h8000_0000;
  localparam logic [31:0] CMAX  = 32'h7fff_ffff;
  localparam logic [31:0] QHALF = 32'h0000_8000;
  localparam logic [31:0] Q1    = 32'h0001_0000;
  localparam logic [31:0] Q5    = 32'h0005_0000;
  localparam logic [31:0] Q10   = 32'h000a_0000;
  localparam int unsigned N_ROWS = 25;
  localparam int unsigned PHASE_REQUESTS = 50;

  // Same bit order as the result tdata: inside flag in bit 0.
  typedef struct packed {
    logic [pipt_pkg::COUNT_OUT_W-1:0] count;
    logic [pipt_pkg::STATUS_W-1:0]    status;
    logic                             in_poly;
  } verdict_t;

  typedef struct packed {
    logic [pipt_pkg::OPCODE_W-1:0] op;
    logic [31:0]                   x;
    logic [31:0]                   y;
    bit                            typed;
    verdict_t                      want;
  } stim_row_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni = 1'b0;
  logic                             s_axis_tvalid = 1'b0;
  logic                             s_axis_tready;
  // coord_x [31:0], coord_y [63:32]
  logic [pipt_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
  // opcode [1:0]
  logic [pipt_pkg::OPCODE_W-1:0]    s_axis_tuser = '0;
  logic                             m_axis_tvalid;
  logic                             m_axis_tready = 1'b0;
  // inside_res [0], status [2:1], vertex_count [11:3], zero [15:12]
  logic [pipt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

  // Predictor copy of the polygon.
  logic signed [31:0] poly_x [MAX_V];
  logic signed [31:0] poly_y [MAX_V];
  int unsigned        poly_len = 0;

  verdict_t pending_verdicts [$];
  int       fail_count = 0;
  int       send_idle_pct = 0;
  int       recv_stall_pct = 0;
  int       hold_left = 0;
  int       requests_sent = 0;

  stim_row_t directed_rows [N_ROWS] = '{
    '{pipt_pkg::OP_QUERY,  32'h0, 32'h0, 1'b1, '{9'd0, pipt_pkg::STAT_DEGENERATE, 1'b0}},
    '{pipt_pkg::OP_APPEND, CMIN,  CMIN,  1'b1, '{9'd1, pipt_pkg::STAT_OK, 1'b0}},
    '{pipt_pkg::OP_QUERY,  CMAX,  CMAX,  1'b1, '{9'd1, pipt_pkg::STAT_DEGENERATE, 1'b0}},
    '{pipt_pkg::OP_APPEND, CMAX,  CMIN,  1'b1, '{9'd2, pipt_pkg::STAT_OK, 1'b0}},
    '{pipt_pkg::OP_QUERY,  32'h0, 32'h0, 1'b1, '{9'd2, pipt_pkg::STAT_DEGENERATE, 1'b0}},
    '{pipt_pkg::OP_APPEND, CMAX,  CMAX,  1'b1, '{9'd3, pipt_pkg::STAT_OK, 1'b0}},
    '{pipt_pkg::OP_QUERY,  32'h0, 32'h0, 1'b0, '0},
    '{pipt_pkg::OP_APPEND, CMIN,  CMAX,  1'b1, '{9'd4, pipt_pkg::STAT_OK, 1'b0}},
    '{pipt_pkg::OP_QUERY,  32'h0, 32'h0, 1'b0, '0},
    '{pipt_pkg::OP_QUERY,  CMIN,  CMIN,  1'b0, '0},
    '{pipt_pkg::OP_QUERY,  CMAX,  CMAX,  1'b0, '0},
    '{pipt_pkg::OP_QUERY,  32'h0, CMIN,  1'b0, '0},
    '{pipt_pkg::OP_QUERY,  CMIN,  32'h0, 1'b0, '0},
    '{OP_UNUSED,           CMAX,  CMIN,  1'b1, '{9'd4, pipt_pkg::STAT_OK, 1'b0}},
    '{pipt_pkg::OP_CLEAR,  32'hffff_ffff, 32'hffff_ffff, 1'b1,
      '{9'd0, pipt_pkg::STAT_OK, 1'b0}},
    '{pipt_pkg::OP_QUERY,  32'h0, 32'h0, 1'b1, '{9'd0, pipt_pkg::STAT_DEGENERATE, 1'b0}},
    '{pipt_pkg::OP_APPEND, 32'h0, 32'h0, 1'b1, '{9'd1, pipt_pkg::STAT_OK, 1'b0}},
    '{pipt_pkg::OP_APPEND, Q10,   32'h0, 1'b1, '{9'd2, pipt_pkg::STAT_OK, 1'b0}},
    '{pipt_pkg::OP_APPEND, 32'h0, Q10,   1'b1, '{9'd3, pipt_pkg::STAT_OK, 1'b0}},
    '{pipt_pkg::OP_QUERY,  Q1,    Q1,    1'b0, '0},
    '{pipt_pkg::OP_QUERY,  32'h0, 32'h0, 1'b0, '0},
    '{pipt_pkg::OP_QUERY,  Q5,    Q5,    1'b0, '0},
    '{pipt_pkg::OP_QUERY,  32'hffff_ffff, Q1, 1'b0, '0},
    '{pipt_pkg::OP_QUERY,  QHALF, Q10,   1'b0, '0},
    '{pipt_pkg::OP_CLEAR,  32'h0, 32'h0, 1'b1, '{9'd0, pipt_pkg::STAT_OK, 1'b0}}
  };

  point_in_polygon_test DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Parity of edges whose crossing with the rightward ray lies strictly right
  // of the point. The division is cross-multiplied out, flipping the
  // comparison when the edge runs downward.
  function automatic logic ray_parity(logic signed [31:0] px, logic signed [31:0] py);
    logic               parity;
    int unsigned        i;
    int unsigned        j;
    logic signed [33:0] dy;
    logic signed [33:0] dpx;
    logic signed [33:0] dex;
    logic signed [33:0] dpy;
    logic signed [67:0] lhs;
    logic signed [67:0] rhs;
    logic               hit;
    parity = 1'b0;
    j = poly_len - 1;
    for (i = 0; i < poly_len; i++) begin
      if ((poly_y[i] > py) != (poly_y[j] > py)) begin
        dy  = poly_y[j] - poly_y[i];
        dpx = px - poly_x[i];
        dex = poly_x[j] - poly_x[i];
        dpy = py - poly_y[i];
        lhs = dpx * dy;
        rhs = dex * dpy;
        hit = (dy > 0) ? (lhs < rhs) : (rhs < lhs);
        if (hit) parity = ~parity;
      end
      j = i;
    end
    return parity;
  endfunction

  function automatic verdict_t predict_verdict(logic [pipt_pkg::OPCODE_W-1:0] op,
                                               logic [31:0] x, logic [31:0] y);
    verdict_t v;
    v = '0;
    case (op)
      pipt_pkg::OP_APPEND: begin
        if (poly_len < MAX_V) begin
          poly_x[poly_len] = x;
          poly_y[poly_len] = y;
          poly_len++;
        end else begin
          v.status = pipt_pkg::STAT_FULL;
        end
      end
      pipt_pkg::OP_CLEAR: poly_len = 0;
      pipt_pkg::OP_QUERY: begin
        if (poly_len < pipt_pkg::MIN_VERTICES) v.status = pipt_pkg::STAT_DEGENERATE;
        else v.in_poly = ray_parity(x, y);
      end
      default: ;
    endcase
    v.count = pipt_pkg::COUNT_OUT_W'(poly_len);
    return v;
  endfunction

  function automatic logic [31:0] rand_coord(int mode);
    logic [31:0] v;
    v = $urandom;
    case (mode)
      0: return {{14{v[17]}}, v[17:0]};
      1: return {{8{v[23]}}, v[23:0]};
      2: return v;
      default: begin
        case ($urandom_range(0, 4))
          0: return CMIN;
          1: return CMAX;
          2: return 32'h0;
          3: return 32'hffff_ffff;
          default: return v;
        endcase
      end
    endcase
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%t: %s", $realtime, msg);
  endtask

  // Offers one request and records its expected result once accepted. A typed
  // expectation replaces the predicted one, but the predictor still advances.
  task automatic send_request(input logic [pipt_pkg::OPCODE_W-1:0] op,
                              input logic [31:0] x, input logic [31:0] y,
                              input bit typed, input verdict_t want);
    verdict_t predicted;
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {y, x};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_verdict(op, x, y);
    pending_verdicts.insert(pending_verdicts.size(), typed ? want : predicted);
    requests_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  // One polygon: usually cleared, filled with a few vertices, then probed with
  // random points and points near its vertices and edges; now and then a single noise request.
  task automatic run_session();
    int          n_vert;
    int          n_query;
    int          mode;
    int          pick;
    int          k;
    int unsigned a;
    int unsigned b;
    logic [31:0] qx;
    logic [31:0] qy;
    if ($urandom_range(0, 9) == 0) begin
      send_request(pipt_pkg::OPCODE_W'($urandom_range(0, 3)), $urandom, $urandom, 1'b0, '0);
    end else begin
      mode = $urandom_range(0, 3);
      if ($urandom_range(0, 4) != 0) begin
        send_request(pipt_pkg::OP_CLEAR, $urandom, $urandom, 1'b0, '0);
      end
      case ($urandom_range(0, 9))
        0: n_vert = $urandom_range(0, 2);
        1: n_vert = $urandom_range(9, 24);
        default: n_vert = $urandom_range(3, 8);
      endcase
      for (k = 0; k < n_vert; k++) begin
        send_request(pipt_pkg::OP_APPEND, rand_coord(mode), rand_coord(mode), 1'b0, '0);
      end
      n_query = $urandom_range(1, 6);
      for (k = 0; k < n_query; k++) begin
        pick = $urandom_range(0, 9);
        qx = rand_coord(mode);
        qy = rand_coord(mode);
        if (poly_len > 0 && pick >= 4 && pick <= 8) begin
          a = $urandom_range(0, poly_len - 1);
          b = $urandom_range(0, poly_len - 1);
          case (pick)
            4, 5: begin
              qx = poly_x[a];
              qy = poly_y[a];
            end
            6, 7: qy = poly_y[a];
            default: begin
              qx = poly_x[a];
              qy = 32'((64'(poly_y[a]) + 64'(poly_y[b])) >>> 1);
            end
          endcase
        end else if (pick == 9) begin
          qx = $urandom;
          qy = $urandom;
        end
        send_request(pipt_pkg::OP_QUERY, qx, qy, 1'b0, '0);
      end
    end
  endtask

  // Result checker and receiver backpressure.
  always @(posedge clk_i) begin
    verdict_t got;
    verdict_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = verdict_t'(m_axis_tdata[11:0]);
        if (pending_verdicts.size() == 0) begin
          note_failure($sformatf("result with none pending: %h", m_axis_tdata));
        end else begin
          want = pending_verdicts.pop_front();
          if (got.in_poly !== want.in_poly || got.status !== want.status ||
              got.count !== want.count) begin
            note_failure($sformatf(
              "mismatch: inside %b/%b status %0d/%0d count %0d/%0d (expected/actual)",
              want.in_poly, got.in_poly, want.status, got.status, want.count, got.count));
          end
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  initial begin
    int phase;
    int start;
    int r;
    int guard;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (r = 0; r < N_ROWS; r++) begin
      send_request(directed_rows[r].op, directed_rows[r].x, directed_rows[r].y,
                   directed_rows[r].typed, directed_rows[r].want);
    end

    for (phase = 0; phase < 4; phase++) begin
      wait_drained();
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      // Receiver holds off while requests keep coming, so the queue backs up.
      if (phase == 0) hold_left = 400;
      start = requests_sent;
      while (requests_sent - start < PHASE_REQUESTS) run_session();
      if (phase == 3) begin
        // Fill the store past capacity, probe the full polygon, send an unused opcode, then empty it.
        send_request(pipt_pkg::OP_CLEAR, 32'h0, 32'h0, 1'b0, '0);
        repeat (MAX_V + 3) begin
          send_request(pipt_pkg::OP_APPEND, rand_coord(2), rand_coord(2), 1'b0, '0);
        end
        repeat (3) send_request(pipt_pkg::OP_QUERY, rand_coord(1), rand_coord(1), 1'b0, '0);
        send_request(OP_UNUSED, $urandom, $urandom, 1'b0, '0);
        send_request(pipt_pkg::OP_CLEAR, $urandom, $urandom, 1'b0, '0);
      end
    end

    s_axis_tvalid <= 1'b0;
    guard = 0;
    while (pending_verdicts.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    while (pending_verdicts.size() != 0) begin
      void'(pending_verdicts.pop_front());
      note_failure("expected result never arrived");
    end
    repeat (300) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
